// File: rtl/bfpq_pkg.sv
// bfpq_pkg: shared constants and operation codes of the bucketed frequency queue
// used by the channel interfaces and the top level; depends on nothing
package bfpq_pkg;

  localparam int OP_W      = 2;
  localparam int SLOT_IN_W = 12;
  localparam int FREQ_IN_W = 16;
  localparam int CFG_W     = 7;
  // wide enough for any bucket count up to 256
  localparam int BCNT_W    = 9;
  // fraction bits of the reciprocal used to reduce the slot field
  localparam int RECIP_SH  = 24;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DEC    = 2'd2,
    OP_INC    = 2'd3
  } op_t;

endpackage

// File: rtl/bfpq_if.sv
// bfpq channel interfaces: request, response and configuration write channels
// depends on bfpq_pkg for field widths
interface bfpq_req_if import bfpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [SLOT_IN_W-1:0] slot;
  logic [FREQ_IN_W-1:0] start_frequency;
  modport source (output valid, op, slot, start_frequency, input ready);
  modport sink (input valid, op, slot, start_frequency, output ready);
endinterface

interface bfpq_rsp_if import bfpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_IN_W-1:0] popped_slot;
  logic [FREQ_IN_W-1:0] popped_frequency;
  logic                 slot_removed;
  logic                 queue_empty;
  logic                 error;
  modport source (output valid, popped_slot, popped_frequency, slot_removed, queue_empty,
                  error, input ready);
  modport sink (input valid, popped_slot, popped_frequency, slot_removed, queue_empty,
                error, output ready);
endinterface

interface bfpq_cfg_if import bfpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/bfpq_slot_mem.sv
// bfpq_slot_mem: per-slot record memory (present, frequency, links)
// one write port, one read port with registered read data; no dependencies
module bfpq_slot_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int W     = 43
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfpq_head_mem.sv
// bfpq_head_mem: bucket head table with per-bucket valid and non-empty flags
// invalid entries read as the null link; no dependencies
module bfpq_head_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 13,
  parameter logic [W-1:0] NIL = 13'd4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [W-1:0]     wdata,
  input  logic [AW-1:0]    raddr,
  output logic [W-1:0]     rdata,
  output logic [DEPTH-1:0] nonempty
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0]     d_q;
  logic             v_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    d_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld      <= '0;
      nonempty <= '0;
      v_q      <= 1'b0;
    end else begin
      v_q <= vld[raddr];
      if (we) begin
        vld[waddr]      <= 1'b1;
        nonempty[waddr] <= (wdata != NIL);
      end
    end
  end

  assign rdata = v_q ? d_q : NIL;

endmodule

// File: rtl/bucketed_frequency_priority_queue.sv
// channel | dir | fields
// req     | in  | op, slot, start_frequency
// rsp     | out | popped_slot, popped_frequency, slot_removed, queue_empty, error
// cfg     | in  | data (bucket count)
//
// an operation runs from its accepting edge to the rsp word; a placed record goes to
// a bucket head, or into the sorted top bucket after a walk past the records ahead of
// it; a downward scan follows when the top bucket empties, and a slot field at or
// above SLOTS first passes through the MOD and MOD2 reduction. the rsp word waits
// while the previous one is still held. after reset and after each cfg word a
// clearing pass runs through the slot memory; req is held off until it ends.
// the next req word is taken while a finished rsp word still waits.
// depends on bfpq_pkg, bfpq_if, bfpq_slot_mem, bfpq_head_mem
module bucketed_frequency_priority_queue import bfpq_pkg::*; #(
  parameter int SLOTS       = 4096,
  parameter int MAX_BUCKETS = 64,
  parameter int FREQ_BITS   = 16
) (
  input logic        clk,
  input logic        rst,
  bfpq_req_if.sink   req,
  bfpq_rsp_if.source rsp,
  bfpq_cfg_if.sink   cfg
);

  localparam int SW  = $clog2(SLOTS);
  localparam int LW  = $clog2(SLOTS + 1);
  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int FB  = FREQ_BITS;
  localparam int WW  = 1 + FB + 2 * LW;
  localparam int RW  = SLOT_IN_W + RECIP_SH;
  localparam bit NEED_MOD = (SLOTS < (1 << SLOT_IN_W));
  localparam logic [LW-1:0] NIL  = LW'(SLOTS);
  localparam logic [FB-1:0] FMAX = {FB{1'b1}};
  // rounded-up reciprocal, exact quotient for any 12-bit slot field
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(((1 << RECIP_SH) + SLOTS - 1) / SLOTS);

  typedef struct packed {
    logic          present;
    logic [FB-1:0] freq;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } sword_t;

  typedef enum logic [4:0] {
    CLR, IDLE, MOD, MOD2, RD_S, POP_H, GOT_S, U0, U1, U2, U3, UE, PL0, PH1, PH2,
    SH1, SW0, SW1, SL, SL2, SL3, FIN, SCAN, DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  bc;
  logic [OP_W-1:0]   op_r;
  logic [SLOT_IN_W-1:0] rem;
  logic [SLOT_IN_W-1:0] quo;
  logic [SW-1:0]     s;
  logic [FB-1:0]     sf;
  sword_t            sw, cw, lw;
  logic [BW-1:0]     bk, top, idx;
  logic              top_valid;
  logic              ae;
  logic [LW-1:0]     cur, last;
  logic [SW-1:0]     clr_cnt;
  logic [SLOT_IN_W-1:0] r_pslot;
  logic [FREQ_IN_W-1:0] r_pfreq;
  logic              r_removed, r_err;

  // memory ports
  logic              s_we;
  logic [SW-1:0]     s_waddr, s_raddr;
  sword_t            s_wdata;
  logic [WW-1:0]     s_rdata;
  logic              h_we;
  logic [BW-1:0]     h_waddr, h_raddr;
  logic [LW-1:0]     h_wdata, h_rdata;
  logic [MAX_BUCKETS-1:0] nonempty;

  logic              cfg_wr, req_acc;
  logic [BCNT_W-1:0] eff_b, bc9;
  sword_t            rd_w;
  logic              rd_top, pl_top, walk_on;
  logic [BW-1:0]     rd_bk, pl_bk;
  logic [RW-1:0]     prod;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign req.ready = (state == IDLE);
  assign req_acc   = req.valid && (state == IDLE);

  assign bc9   = BCNT_W'(bc);
  assign eff_b = (bc9 == '0) ? BCNT_W'(1) :
                 ((bc9 > BCNT_W'(MAX_BUCKETS)) ? BCNT_W'(MAX_BUCKETS) : bc9);

  assign rd_w    = sword_t'(s_rdata);
  assign rd_top  = 33'(rd_w.freq) >= 33'(eff_b);
  assign rd_bk   = rd_top ? BW'(eff_b - BCNT_W'(1)) : BW'(rd_w.freq - FB'(1));
  assign pl_top  = 33'(sw.freq) >= 33'(eff_b);
  assign pl_bk   = pl_top ? BW'(eff_b - BCNT_W'(1)) : BW'(sw.freq - FB'(1));
  assign walk_on = (rd_w.freq > sw.freq) || (ae && (rd_w.freq == sw.freq));
  assign prod    = RW'(rem) * RW'(RECIP);

  bfpq_slot_mem #(.DEPTH(SLOTS), .AW(SW), .W(WW)) u_slot (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  bfpq_head_mem #(.DEPTH(MAX_BUCKETS), .AW(BW), .W(LW), .NIL(NIL)) u_head (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_wr),
    .we       (h_we),
    .waddr    (h_waddr),
    .wdata    (h_wdata),
    .raddr    (h_raddr),
    .rdata    (h_rdata),
    .nonempty (nonempty)
  );

  // memory port drive per state
  always_comb begin
    s_we    = 1'b0;
    s_waddr = s;
    s_wdata = sw;
    s_raddr = s;
    h_we    = 1'b0;
    h_waddr = bk;
    h_wdata = NIL;
    h_raddr = bk;
    case (state)
      CLR: begin
        s_we    = 1'b1;
        s_waddr = clr_cnt;
        s_wdata = '0;
      end
      IDLE: h_raddr = top;
      RD_S: s_raddr = SW'(rem);
      POP_H: s_raddr = SW'(h_rdata);
      U0: s_raddr = SW'(sw.nxt);
      U1: begin
        s_we    = 1'b1;
        s_waddr = SW'(sw.nxt);
        s_wdata = rd_w;
        s_wdata.prv = sw.prv;
      end
      U2: begin
        if (sw.prv < NIL) begin
          s_raddr = SW'(sw.prv);
        end else begin
          h_we    = 1'b1;
          h_wdata = sw.nxt;
        end
      end
      U3: begin
        s_we    = 1'b1;
        s_waddr = SW'(sw.prv);
        s_wdata = rd_w;
        s_wdata.nxt = sw.nxt;
      end
      UE: begin
        if ((op_r == OP_POP) || ((op_r == OP_DEC) && (sw.freq == FB'(1)))) begin
          s_we    = 1'b1;
          s_wdata = '{present: 1'b0, freq: '0, nxt: NIL, prv: NIL};
        end
      end
      PL0: h_raddr = pl_bk;
      PH1: begin
        s_we    = 1'b1;
        s_wdata = '{present: 1'b1, freq: sw.freq, nxt: h_rdata, prv: NIL};
        s_raddr = SW'(h_rdata);
        h_we    = 1'b1;
        h_wdata = LW'(s);
      end
      PH2: begin
        s_we    = 1'b1;
        s_waddr = SW'(cur);
        s_wdata = rd_w;
        s_wdata.prv = LW'(s);
      end
      SW0: s_raddr = SW'(cur);
      SL: begin
        s_we    = 1'b1;
        s_wdata = '{present: 1'b1, freq: sw.freq, nxt: cur, prv: last};
      end
      SL2: begin
        s_we    = 1'b1;
        s_waddr = SW'(cur);
        s_wdata = cw;
        s_wdata.prv = LW'(s);
      end
      SL3: begin
        if (last < NIL) begin
          s_we    = 1'b1;
          s_waddr = SW'(last);
          s_wdata = lw;
          s_wdata.nxt = LW'(s);
        end else begin
          h_we    = 1'b1;
          h_wdata = LW'(s);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLR;
      clr_cnt   <= '0;
      bc        <= CFG_W'(64);
      top_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      // a live head entering above the current top becomes the top
      if (h_we && (h_wdata < NIL) && (!top_valid || (h_waddr > top))) begin
        top       <= h_waddr;
        top_valid <= 1'b1;
      end
      case (state)
        CLR: begin
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_cnt == SW'(SLOTS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req_acc) begin
            op_r      <= req.op;
            rem       <= req.slot;
            sf        <= FB'(req.start_frequency);
            r_pslot   <= '0;
            r_pfreq   <= '0;
            r_removed <= 1'b0;
            r_err     <= 1'b0;
            ae        <= 1'b0;
            if (req.op == OP_POP) begin
              if (top_valid) begin
                bk    <= top;
                state <= POP_H;
              end else begin
                r_err <= 1'b1;
                state <= FIN;
              end
            end else if (NEED_MOD && (17'(req.slot) >= 17'(SLOTS))) begin
              state <= MOD;
            end else begin
              state <= RD_S;
            end
          end
        end
        MOD: begin
          // quotient by reciprocal multiplication
          quo   <= prod[RW-1:RECIP_SH];
          state <= MOD2;
        end
        MOD2: begin
          rem   <= rem - SLOT_IN_W'(SLOT_IN_W'(SLOTS) * quo);
          state <= RD_S;
        end
        RD_S: begin
          s     <= SW'(rem);
          state <= GOT_S;
        end
        POP_H: begin
          s     <= SW'(h_rdata);
          state <= GOT_S;
        end
        GOT_S: begin
          sw <= rd_w;
          case (op_r)
            OP_INSERT: begin
              if (rd_w.present || (sf == '0)) begin
                state <= FIN;
              end else begin
                sw.present <= 1'b1;
                sw.freq    <= sf;
                state      <= PL0;
              end
            end
            OP_POP: begin
              r_pslot <= SLOT_IN_W'(s);
              r_pfreq <= FREQ_IN_W'(rd_w.freq);
              state   <= U0;
            end
            OP_DEC: begin
              bk    <= rd_bk;
              state <= rd_w.present ? U0 : FIN;
            end
            default: begin
              bk <= rd_bk;
              ae <= rd_top;
              if (!rd_w.present) begin
                r_err <= 1'b1;
                state <= FIN;
              end else if (rd_w.freq == FMAX) begin
                state <= FIN;
              end else begin
                state <= U0;
              end
            end
          endcase
        end
        U0: state <= (sw.nxt < NIL) ? U1 : U2;
        U1: state <= U2;
        U2: state <= (sw.prv < NIL) ? U3 : UE;
        U3: state <= UE;
        UE: begin
          case (op_r)
            OP_POP: state <= FIN;
            OP_DEC: begin
              sw.freq <= sw.freq - FB'(1);
              if (sw.freq == FB'(1)) begin
                r_removed <= 1'b1;
                state     <= FIN;
              end else begin
                state <= PL0;
              end
            end
            default: begin
              sw.freq <= sw.freq + FB'(1);
              state   <= PL0;
            end
          endcase
        end
        PL0: begin
          bk    <= pl_bk;
          state <= pl_top ? SH1 : PH1;
        end
        PH1: begin
          cur   <= h_rdata;
          state <= (h_rdata < NIL) ? PH2 : FIN;
        end
        PH2: state <= FIN;
        SH1: begin
          cur   <= h_rdata;
          last  <= NIL;
          state <= SW0;
        end
        SW0: state <= (cur < NIL) ? SW1 : SL;
        SW1: begin
          cw <= rd_w;
          if (walk_on) begin
            last  <= cur;
            lw    <= rd_w;
            cur   <= rd_w.nxt;
            state <= SW0;
          end else begin
            state <= SL;
          end
        end
        SL: state <= (cur < NIL) ? SL2 : SL3;
        SL2: state <= SL3;
        SL3: state <= FIN;
        FIN: begin
          if (top_valid && !nonempty[top]) begin
            idx   <= top;
            state <= SCAN;
          end else begin
            state <= DONE;
          end
        end
        SCAN: begin
          // walk down to the highest bucket that still holds a record
          if (nonempty[idx]) begin
            top   <= idx;
            state <= DONE;
          end else if (idx == '0) begin
            top_valid <= 1'b0;
            state     <= DONE;
          end else begin
            idx <= idx - BW'(1);
          end
        end
        DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid            <= 1'b1;
            rsp.popped_slot      <= r_pslot;
            rsp.popped_frequency <= r_pfreq;
            rsp.slot_removed     <= r_removed;
            rsp.queue_empty      <= !top_valid;
            rsp.error            <= r_err;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (cfg_wr) begin
        bc        <= cfg.data;
        top_valid <= 1'b0;
        clr_cnt   <= '0;
        state     <= CLR;
      end
    end
  end

endmodule
